// File: rtl/social_proxemic_cell_cost_unit_macros.svh
// Assertion macros used by the port-level checker.
`ifndef SOCIAL_PROXEMIC_CELL_COST_UNIT_MACROS_SVH
`define SOCIAL_PROXEMIC_CELL_COST_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SPROX_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define SPROX_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sprox_pkg.sv
// Package: types, codes and constants of the social proxemic cost unit.
`timescale 1ns / 1ps
`default_nettype none
package sprox_pkg;

   localparam int MAX_PERSONS_DEF = 16;
   localparam int POS_W    = 24;
   localparam int VEL_W    = 16;
   localparam int IDX_W    = 12;
   localparam int COST_W   = 7;
   localparam int PERSON_W = 2 * POS_W + 2 * VEL_W;
   localparam int NUM_W    = 104;
   localparam int CSR_IW   = 3;
   localparam int CSR_DW   = 24;
   localparam int COST_SCALE = 200;

   localparam logic [15:0] MAJOR_RST  = 16'd2560;
   localparam logic [15:0] MINOR_RST  = 16'd1024;
   localparam logic [15:0] RADIUS_RST = 16'd819;
   localparam logic [15:0] CUTOFF_RST = 16'd3072;
   localparam logic [23:0] ORIGIN_RST = 24'd0;
   localparam logic [15:0] CELL_RST   = 16'd51;

   typedef enum logic [1:0] {
      REQ_CLEAR = 2'd0,
      REQ_ADD   = 2'd1,
      REQ_QUERY = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      CSR_MAJOR    = 3'd0,
      CSR_MINOR    = 3'd1,
      CSR_RADIUS   = 3'd2,
      CSR_CUTOFF   = 3'd3,
      CSR_ORIGIN_X = 3'd4,
      CSR_ORIGIN_Y = 3'd5,
      CSR_CELL     = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [15:0] fwd_axis;
      logic [15:0] side_axis;
      logic [15:0] rear_radius;
      logic [15:0] cut_range;
      logic [23:0] grid_origin_x;
      logic [23:0] grid_origin_y;
      logic [15:0] cell_size;
   } cfg_type;

   typedef struct packed {
      logic idle;
      logic res_valid;
   } core_stat_type;

   typedef enum logic [5:0] {
      S_IDLE, S_CX, S_CY, S_CUT, S_MAJ, S_MIN, S_B2, S_LOOP, S_DX,
      S_SQX, S_SQY, S_VX, S_VY, S_AX, S_AY, S_BX, S_BY, S_SEL, S_BR,
      S_E1, S_E2, S_E3, S_E4, S_E5, S_E6, S_E7, S_E8, S_E9, S_E10,
      S_E11, S_E12, S_E13, S_E14, S_EDIV,
      S_QI, S_QC, S_RC, S_RN, S_WAIT, S_NEXT, S_DONE
   } core_state_type;

endpackage
`default_nettype wire

// File: rtl/sprox_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module sprox_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// File: rtl/sprox_mul.sv
// Shared signed 33x33 multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module sprox_mul (
   input  logic               clock,
   input  logic signed [32:0] op_a,
   input  logic signed [32:0] op_b,
   output logic signed [65:0] prod
);
   logic signed [65:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

// File: rtl/sprox_div.sv
// Restoring divider, one quotient bit per cycle, small quotient.
`timescale 1ns / 1ps
`default_nettype none
module sprox_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [sprox_pkg::NUM_W-1:0]      num,
   input  logic [sprox_pkg::NUM_W-1:0]      den,
   output logic                             done,
   output logic [sprox_pkg::COST_W-1:0]     quot
);
   import sprox_pkg::*;

   localparam int CNT_W = $clog2(COST_W + 1);

   logic [NUM_W-1:0]  rem_ff, rem_in, den_ff, den_in;
   logic [COST_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num;
         den_in  = den << (COST_W - 1);
         q_in    = '0;
         cnt_in  = CNT_W'(COST_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= den_ff) begin
            rem_in = rem_ff - den_ff;
            q_in   = {q_ff[COST_W-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[COST_W-2:0], 1'b0};
         end
         den_in = den_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

// File: rtl/sprox_core.sv
// Query sequencer: walks the person table through the shared multiplier and divider.
`timescale 1ns / 1ps
`default_nettype none
module sprox_core #(
   parameter int MAX_PERSONS = sprox_pkg::MAX_PERSONS_DEF,
   localparam int AW = (MAX_PERSONS > 1) ? $clog2(MAX_PERSONS) : 1,
   localparam int CW = $clog2(MAX_PERSONS + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [sprox_pkg::IDX_W-1:0]     col,
   input  logic [sprox_pkg::IDX_W-1:0]     row,
   input  sprox_pkg::cfg_type              cfg,
   input  logic [CW-1:0]                   count,
   output logic [AW-1:0]                   rd_addr,
   input  logic [sprox_pkg::PERSON_W-1:0]  rd_data,
   input  logic                            res_take,
   output sprox_pkg::core_stat_type        stat,
   output logic [sprox_pkg::COST_W-1:0]    cost
);
   import sprox_pkg::*;

   core_state_type state_ff, state_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [IDX_W:0]    cm_ff, cm_in, rm_ff, rm_in;
   logic [31:0]       cx_ff, cx_in, cy_ff, cy_in, dx_ff, dx_in, dy_ff, dy_in;
   logic [VEL_W-1:0]  vx_ff, vx_in, vy_ff, vy_in;
   logic [31:0]       cut2_ff, cut2_in, a2_ff, a2_in, b2_ff, b2_in, s_ff, s_in;
   logic [63:0]       dist2_ff, dist2_in, asq_ff, asq_in, bsq_ff, bsq_in, sa_ff, sa_in;
   logic [33:0]       av_ff, av_in, bv_ff, bv_in;
   logic [127:0]      acc_ff, acc_in, n_ff, n_in, d_ff, d_in;
   logic [16:0]       root_ff, root_in;
   logic [4:0]        sq_ff, sq_in;
   logic [COST_W-1:0] best_ff, best_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   logic [63:0]        pu;
   logic               div_start, div_done;
   logic [NUM_W-1:0]   div_num, div_den;
   logic [COST_W-1:0]  div_q;

   logic [33:0] amag, bmag;
   logic [16:0] tbit;
   logic [15:0] rdiff;
   logic [POS_W-1:0] px, py;

   sprox_mul u_mul (.clock(clock), .op_a(mul_a), .op_b(mul_b), .prod(mul_p));

   sprox_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .done(div_done), .quot(div_q)
   );

   assign pu      = mul_p[63:0];
   assign rd_addr = idx_ff[AW-1:0];
   assign px      = rd_data[PERSON_W-1 -: POS_W];
   assign py      = rd_data[PERSON_W-POS_W-1 -: POS_W];
   assign amag    = av_ff[33] ? (~av_ff + 34'd1) : av_ff;
   assign bmag    = bv_ff[33] ? (~bv_ff + 34'd1) : bv_ff;
   assign tbit    = root_ff | (17'd1 << sq_ff);
   assign rdiff   = cfg.rear_radius - root_ff[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff   <= idx_in;
      cm_ff    <= cm_in;
      rm_ff    <= rm_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      vx_ff    <= vx_in;
      vy_ff    <= vy_in;
      cut2_ff  <= cut2_in;
      a2_ff    <= a2_in;
      b2_ff    <= b2_in;
      s_ff     <= s_in;
      dist2_ff <= dist2_in;
      asq_ff   <= asq_in;
      bsq_ff   <= bsq_in;
      sa_ff    <= sa_in;
      av_ff    <= av_in;
      bv_ff    <= bv_in;
      acc_ff   <= acc_in;
      n_ff     <= n_in;
      d_ff     <= d_in;
      root_ff  <= root_in;
      sq_ff    <= sq_in;
      best_ff  <= best_in;
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;   cm_in = cm_ff;     rm_in = rm_ff;
      cx_in = cx_ff;     cy_in = cy_ff;     dx_in = dx_ff;   dy_in = dy_ff;
      vx_in = vx_ff;     vy_in = vy_ff;     cut2_in = cut2_ff;
      a2_in = a2_ff;     b2_in = b2_ff;     s_in = s_ff;     dist2_in = dist2_ff;
      asq_in = asq_ff;   bsq_in = bsq_ff;   sa_in = sa_ff;
      av_in = av_ff;     bv_in = bv_ff;     acc_in = acc_ff;
      n_in = n_ff;       d_in = d_ff;       root_in = root_ff;
      sq_in = sq_ff;     best_in = best_ff;
      mul_a = '0;
      mul_b = '0;
      div_start = 1'b0;
      div_num = acc_ff[NUM_W-1:0];
      div_den = {d_ff[NUM_W-2:0], 1'b0};
      stat.idle = 1'b0;
      stat.res_valid = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            stat.idle = 1'b1;
            if (start) begin
               cm_in = {col, 1'b1};
               rm_in = {row, 1'b1};
               best_in = '0;
               idx_in = '0;
               state_in = S_CX;
            end
         end
         S_CX: begin
            mul_a = {20'd0, cm_ff};
            mul_b = {17'd0, cfg.cell_size};
            state_in = S_CY;
         end
         S_CY: begin
            cx_in = {{8{cfg.grid_origin_x[23]}}, cfg.grid_origin_x} + {4'd0, pu[28:1]};
            mul_a = {20'd0, rm_ff};
            mul_b = {17'd0, cfg.cell_size};
            state_in = S_CUT;
         end
         S_CUT: begin
            cy_in = {{8{cfg.grid_origin_y[23]}}, cfg.grid_origin_y} + {4'd0, pu[28:1]};
            mul_a = {17'd0, cfg.cut_range};
            mul_b = {17'd0, cfg.cut_range};
            state_in = S_MAJ;
         end
         S_MAJ: begin
            cut2_in = pu[31:0];
            mul_a = {17'd0, cfg.fwd_axis};
            mul_b = {17'd0, cfg.fwd_axis};
            state_in = S_MIN;
         end
         S_MIN: begin
            a2_in = pu[31:0];
            mul_a = {17'd0, cfg.side_axis};
            mul_b = {17'd0, cfg.side_axis};
            state_in = S_B2;
         end
         S_B2: begin
            b2_in = pu[31:0];
            state_in = S_LOOP;
         end
         S_LOOP: begin
            state_in = (idx_ff < count) ? S_DX : S_DONE;
         end
         S_DX: begin
            dx_in = cx_ff - {{8{px[23]}}, px};
            dy_in = cy_ff - {{8{py[23]}}, py};
            vx_in = rd_data[2*VEL_W-1 -: VEL_W];
            vy_in = rd_data[VEL_W-1:0];
            state_in = S_SQX;
         end
         S_SQX: begin
            mul_a = {dx_ff[31], dx_ff};
            mul_b = {dx_ff[31], dx_ff};
            state_in = S_SQY;
         end
         S_SQY: begin
            dist2_in = pu;
            mul_a = {dy_ff[31], dy_ff};
            mul_b = {dy_ff[31], dy_ff};
            state_in = S_VX;
         end
         S_VX: begin
            dist2_in = dist2_ff + pu;
            mul_a = {{17{vx_ff[15]}}, vx_ff};
            mul_b = {{17{vx_ff[15]}}, vx_ff};
            state_in = S_VY;
         end
         S_VY: begin
            if (dist2_ff > {32'd0, cut2_ff}) begin
               state_in = S_NEXT;
            end else begin
               s_in = pu[31:0];
               mul_a = {{17{vy_ff[15]}}, vy_ff};
               mul_b = {{17{vy_ff[15]}}, vy_ff};
               state_in = S_AX;
            end
         end
         S_AX: begin
            s_in = s_ff + pu[31:0];
            mul_a = {dx_ff[31], dx_ff};
            mul_b = {{17{vx_ff[15]}}, vx_ff};
            state_in = S_AY;
         end
         S_AY: begin
            av_in = pu[33:0];
            mul_a = {dy_ff[31], dy_ff};
            mul_b = {{17{vy_ff[15]}}, vy_ff};
            state_in = S_BX;
         end
         S_BX: begin
            av_in = av_ff + pu[33:0];
            mul_a = {dy_ff[31], dy_ff};
            mul_b = {{17{vx_ff[15]}}, vx_ff};
            state_in = S_BY;
         end
         S_BY: begin
            bv_in = pu[33:0];
            mul_a = {dx_ff[31], dx_ff};
            mul_b = {{17{vy_ff[15]}}, vy_ff};
            state_in = S_SEL;
         end
         S_SEL: begin
            if (s_ff <= 32'd1) begin
               av_in = {{2{dx_ff[31]}}, dx_ff};
               bv_in = {{2{dy_ff[31]}}, dy_ff};
               s_in = 32'd1;
            end else begin
               bv_in = bv_ff - pu[33:0];
            end
            state_in = S_BR;
         end
         S_BR: begin
            if (!av_ff[33]) begin
               if (cfg.fwd_axis == '0 || cfg.side_axis == '0) begin
                  state_in = S_NEXT;
               end else begin
                  mul_a = {1'b0, amag[31:0]};
                  mul_b = {1'b0, amag[31:0]};
                  state_in = S_E1;
               end
            end else begin
               root_in = '0;
               sq_in = 5'd16;
               state_in = S_QI;
            end
         end
         S_E1: begin
            asq_in = pu;
            mul_a = {1'b0, bmag[31:0]};
            mul_b = {1'b0, bmag[31:0]};
            state_in = S_E2;
         end
         S_E2: begin
            bsq_in = pu;
            mul_a = {1'b0, asq_ff[31:0]};
            mul_b = {1'b0, b2_ff};
            state_in = S_E3;
         end
         S_E3: begin
            acc_in = {64'd0, pu};
            mul_a = {1'b0, asq_ff[63:32]};
            mul_b = {1'b0, b2_ff};
            state_in = S_E4;
         end
         S_E4: begin
            acc_in = acc_ff + {32'd0, pu, 32'd0};
            mul_a = {1'b0, bsq_ff[31:0]};
            mul_b = {1'b0, a2_ff};
            state_in = S_E5;
         end
         S_E5: begin
            acc_in = acc_ff + {64'd0, pu};
            mul_a = {1'b0, bsq_ff[63:32]};
            mul_b = {1'b0, a2_ff};
            state_in = S_E6;
         end
         S_E6: begin
            n_in = acc_ff + {32'd0, pu, 32'd0};
            mul_a = {1'b0, s_ff};
            mul_b = {1'b0, a2_ff};
            state_in = S_E7;
         end
         S_E7: begin
            sa_in = pu;
            state_in = S_E8;
         end
         S_E8: begin
            mul_a = {1'b0, sa_ff[31:0]};
            mul_b = {1'b0, b2_ff};
            state_in = S_E9;
         end
         S_E9: begin
            acc_in = {64'd0, pu};
            mul_a = {1'b0, sa_ff[63:32]};
            mul_b = {1'b0, b2_ff};
            state_in = S_E10;
         end
         S_E10: begin
            d_in = acc_ff + {32'd0, pu, 32'd0};
            state_in = S_E11;
         end
         S_E11: begin
            if (n_ff > d_ff) begin
               state_in = S_NEXT;
            end else begin
               n_in = d_ff - n_ff;
               state_in = S_E12;
            end
         end
         S_E12: begin
            // 201*D - 200*N as 200*(D - N) + D
            acc_in = (n_ff << 7) + (n_ff << 6);
            state_in = S_E13;
         end
         S_E13: begin
            acc_in = acc_ff + (n_ff << 3);
            state_in = S_E14;
         end
         S_E14: begin
            acc_in = acc_ff + d_ff;
            state_in = S_EDIV;
         end
         S_EDIV: begin
            div_start = 1'b1;
            state_in = S_WAIT;
         end
         S_QI: begin
            mul_a = {16'd0, tbit};
            mul_b = {16'd0, tbit};
            state_in = S_QC;
         end
         S_QC: begin
            if (pu <= dist2_ff) begin
               root_in = tbit;
            end
            if (sq_ff == 5'd0) begin
               state_in = S_RC;
            end else begin
               sq_in = sq_ff - 5'd1;
               state_in = S_QI;
            end
         end
         S_RC: begin
            if (cfg.rear_radius == '0 || root_ff > {1'b0, cfg.rear_radius}) begin
               state_in = S_NEXT;
            end else begin
               mul_a = {17'd0, rdiff};
               mul_b = 33'(COST_SCALE);
               state_in = S_RN;
            end
         end
         S_RN: begin
            div_start = 1'b1;
            div_num = {40'd0, pu} + {88'd0, cfg.rear_radius};
            div_den = {87'd0, cfg.rear_radius, 1'b0};
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_done) begin
               if (div_q > best_ff) begin
                  best_in = div_q;
               end
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            idx_in = idx_ff + CW'(1);
            state_in = S_LOOP;
         end
         S_DONE: begin
            stat.res_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign cost = best_ff;
endmodule
`default_nettype wire

// File: rtl/social_proxemic_cell_cost_unit.sv
// Top level of the social proxemic cell cost unit.
//
//  channel | ports             | direction | moves
//  req     | req_valid/ready   | in        | clear, add person or cell query
//  rsp     | rsp_valid/ready   | out       | cost of one queried cell
//  csr     | csr_valid/ready   | in        | register index and write data
//
// Clear and add leave the core idle, so another request can follow each one. A query
// runs its setup steps, then per person stops early if out of cutoff; in the rear circle
// it takes 17 square root steps on the shared multiplier, then a divide, and ahead it
// takes wide products cut into 32x32 passes, then the divide, before it finishes.
// Reset clears the person count, the registers to their reset values and rsp.
// A finished query waits in the core until the rsp register is free.
`timescale 1ns / 1ps
`default_nettype none
module social_proxemic_cell_cost_unit #(
   parameter int MAX_PERSONS = sprox_pkg::MAX_PERSONS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_type,
   input  logic [sprox_pkg::POS_W-1:0]     req_person_x,
   input  logic [sprox_pkg::POS_W-1:0]     req_person_y,
   input  logic [sprox_pkg::VEL_W-1:0]     req_person_vx,
   input  logic [sprox_pkg::VEL_W-1:0]     req_person_vy,
   input  logic [sprox_pkg::IDX_W-1:0]     req_cell_col,
   input  logic [sprox_pkg::IDX_W-1:0]     req_cell_row,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sprox_pkg::COST_W-1:0]    rsp_cell_cost,
   output logic [sprox_pkg::IDX_W-1:0]     rsp_out_col,
   output logic [sprox_pkg::IDX_W-1:0]     rsp_out_row,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sprox_pkg::CSR_IW-1:0]    csr_index,
   input  logic [sprox_pkg::CSR_DW-1:0]    csr_wdata
);
   import sprox_pkg::*;

   localparam int AW = (MAX_PERSONS > 1) ? $clog2(MAX_PERSONS) : 1;
   localparam int CW = $clog2(MAX_PERSONS + 1);

   cfg_type           cfg_ff, cfg_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]  col_ff, col_in, row_ff, row_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [COST_W-1:0] rsp_cost_ff, rsp_cost_in;
   logic [IDX_W-1:0]  rsp_col_ff, rsp_col_in, rsp_row_ff, rsp_row_in;

   logic              req_fire, ram_we, core_start, res_take;
   logic [AW-1:0]     rd_addr;
   logic [PERSON_W-1:0] rd_data;
   core_stat_type     stat;
   logic [COST_W-1:0] core_cost;

   sprox_ram #(.WIDTH(PERSON_W), .DEPTH(MAX_PERSONS)) u_ram (
      .clock(clock), .we(ram_we), .waddr(count_ff[AW-1:0]),
      .wdata({req_person_x, req_person_y, req_person_vx, req_person_vy}),
      .raddr(rd_addr), .rdata(rd_data)
   );

   sprox_core #(.MAX_PERSONS(MAX_PERSONS)) u_core (
      .clock(clock), .reset(reset), .start(core_start), .col(req_cell_col),
      .row(req_cell_row), .cfg(cfg_ff), .count(count_ff), .rd_addr(rd_addr),
      .rd_data(rd_data), .res_take(res_take), .stat(stat), .cost(core_cost)
   );

   assign req_ready = stat.idle;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign res_take  = stat.res_valid && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{fwd_axis: MAJOR_RST, side_axis: MINOR_RST,
                     rear_radius: RADIUS_RST, cut_range: CUTOFF_RST,
                     grid_origin_x: ORIGIN_RST, grid_origin_y: ORIGIN_RST,
                     cell_size: CELL_RST};
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff      <= col_in;
      row_ff      <= row_in;
      rsp_cost_ff <= rsp_cost_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAJOR:    cfg_in.fwd_axis      = csr_wdata[15:0];
            CSR_MINOR:    cfg_in.side_axis     = csr_wdata[15:0];
            CSR_RADIUS:   cfg_in.rear_radius   = csr_wdata[15:0];
            CSR_CUTOFF:   cfg_in.cut_range     = csr_wdata[15:0];
            CSR_ORIGIN_X: cfg_in.grid_origin_x = csr_wdata;
            CSR_ORIGIN_Y: cfg_in.grid_origin_y = csr_wdata;
            CSR_CELL:     cfg_in.cell_size     = csr_wdata[15:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      count_in   = count_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      ram_we     = 1'b0;
      core_start = 1'b0;
      if (req_fire) begin
         unique case (req_type)
            REQ_CLEAR: count_in = '0;
            REQ_ADD: begin
               if (count_ff < CW'(MAX_PERSONS)) begin
                  ram_we   = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            REQ_QUERY: begin
               core_start = 1'b1;
               col_in = req_cell_col;
               row_in = req_cell_row;
            end
            default: count_in = count_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_cost_in  = rsp_cost_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_cost_in  = core_cost;
         rsp_col_in   = col_ff;
         rsp_row_in   = row_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell_cost = rsp_cost_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_row   = rsp_row_ff;
endmodule
`default_nettype wire

// File: rtl/sprox_checker.sv
// Port-level checker for the social proxemic cell cost unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "social_proxemic_cell_cost_unit_macros.svh"
module sprox_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [1:0]                   req_type,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [sprox_pkg::COST_W-1:0] rsp_cell_cost
);
   import sprox_pkg::*;

   `SPROX_ASSERT_NOW(a_cost_range, rsp_valid, rsp_cell_cost <= 7'd100, "cost above 100")
   `SPROX_ASSERT_NEXT(a_query_busy, req_valid && req_ready && req_type == REQ_QUERY, !req_ready, "ready after query")
   `SPROX_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_cell_cost), "rsp dropped")
   `SPROX_ASSERT_NEXT(a_noq_norsp, !rsp_valid && req_ready && !(req_valid && req_type == REQ_QUERY), !rsp_valid, "rsp without query")
endmodule

bind social_proxemic_cell_cost_unit sprox_checker u_sprox_checker (.*);
`default_nettype wire

// File: dv/tb_social_proxemic_cell_cost_unit.sv
// Self-checking testbench for the social proxemic cell cost unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_social_proxemic_cell_cost_unit;
   import sprox_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int TABLE_DEPTH = 16;
   localparam int STALL_LIMIT = 6000;
   localparam int LONG_HOLD = 700;

   typedef struct {
      logic [1:0]  kind;
      logic [23:0] x;
      logic [23:0] y;
      logic [15:0] vx;
      logic [15:0] vy;
      logic [11:0] col;
      logic [11:0] row;
   } request_type;

   typedef struct {
      logic [6:0]  cost;
      logic [11:0] col;
      logic [11:0] row;
   } cell_cost_type;

   class proxemic_scoreboard;
      int fails;
      cell_cost_type cost_q[$];
      logic [15:0] major, minor, radius, cutoff, cell_sz;
      longint org_x, org_y;
      longint px[TABLE_DEPTH], py[TABLE_DEPTH], pvx[TABLE_DEPTH], pvy[TABLE_DEPTH];
      int unsigned count;

      function new();
         fails = 0;
         count = 0;
         major = MAJOR_RST;
         minor = MINOR_RST;
         radius = RADIUS_RST;
         cutoff = CUTOFF_RST;
         cell_sz = CELL_RST;
         org_x = 0;
         org_y = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [23:0] v);
         case (idx)
            CSR_MAJOR:    major = v[15:0];
            CSR_MINOR:    minor = v[15:0];
            CSR_RADIUS:   radius = v[15:0];
            CSR_CUTOFF:   cutoff = v[15:0];
            CSR_ORIGIN_X: org_x = longint'($signed(v));
            CSR_ORIGIN_Y: org_y = longint'($signed(v));
            CSR_CELL:     cell_sz = v[15:0];
            default: ;
         endcase
      endfunction

      function longint centre(longint org, logic [11:0] idx);
         logic [63:0] span;
         span = ((64'(idx) * 2 + 1) * 64'(cell_sz)) >> 1;
         return org + longint'(span);
      endfunction

      function logic [63:0] mag(longint v);
         return v < 0 ? 64'(-v) : 64'(v);
      endfunction

      function int unsigned person_cost(longint dx, longint dy, longint vx, longint vy);
         logic [63:0] dist2, s, a2, b2, a_sq, b_sq, root, t;
         logic [127:0] num, den;
         longint along, across;
         dist2 = mag(dx) * mag(dx) + mag(dy) * mag(dy);
         if (dist2 > 64'(cutoff) * 64'(cutoff)) return 0;
         s = mag(vx) * mag(vx) + mag(vy) * mag(vy);
         if (s <= 1) begin
            along = dx;
            across = dy;
            s = 1;
         end else begin
            along = dx * vx + dy * vy;
            across = dy * vx - dx * vy;
         end
         if (along >= 0) begin
            if (major == 0 || minor == 0) return 0;
            a2 = 64'(major) * 64'(major);
            b2 = 64'(minor) * 64'(minor);
            a_sq = mag(along) * mag(along);
            b_sq = mag(across) * mag(across);
            num = 128'(a_sq) * 128'(b2) + 128'(b_sq) * 128'(a2);
            den = 128'(s * a2) * 128'(b2);
            if (num > den) return 0;
            for (int k = 100; k >= 1; k--)
               if (num * 200 <= den * (201 - 2 * k)) return k;
            return 0;
         end
         root = 0;
         for (int b = 16; b >= 0; b--) begin
            t = root | (64'd1 << b);
            if (t * t <= dist2) root = t;
         end
         if (radius == 0 || root > 64'(radius)) return 0;
         return int'((201 * 64'(radius) - 200 * root) / (2 * 64'(radius)));
      endfunction

      function void note_request(request_type r);
         cell_cost_type e;
         longint cx, cy;
         int unsigned best, c;
         case (r.kind)
            REQ_CLEAR: count = 0;
            REQ_ADD: if (count < TABLE_DEPTH) begin
               px[count] = longint'($signed(r.x));
               py[count] = longint'($signed(r.y));
               pvx[count] = longint'($signed(r.vx));
               pvy[count] = longint'($signed(r.vy));
               count++;
            end
            REQ_QUERY: begin
               cx = centre(org_x, r.col);
               cy = centre(org_y, r.row);
               best = 0;
               for (int i = 0; i < count; i++) begin
                  c = person_cost(cx - px[i], cy - py[i], pvx[i], pvy[i]);
                  if (c > best) best = c;
               end
               e.cost = best[6:0];
               e.col = r.col;
               e.row = r.row;
               cost_q = {cost_q, e};
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [6:0] cost, logic [11:0] col, logic [11:0] row);
         cell_cost_type e;
         if (cost_q.size() == 0) begin
            $display("%0t: unexpected transaction cost=%0d col=%0d row=%0d",
                     $time, cost, col, row);
            fails++;
            return;
         end
         e = cost_q.pop_front();
         if (cost !== e.cost) begin
            $display("%0t: cost expected %0d actual %0d (col %0d row %0d)",
                     $time, e.cost, cost, e.col, e.row);
            fails++;
         end
         if (col !== e.col) begin
            $display("%0t: col expected %0d actual %0d", $time, e.col, col);
            fails++;
         end
         if (row !== e.row) begin
            $display("%0t: row expected %0d actual %0d", $time, e.row, row);
            fails++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_type = 2'd0;
   logic [23:0] req_person_x = '0, req_person_y = '0;
   logic [15:0] req_person_vx = '0, req_person_vy = '0;
   logic [11:0] req_cell_col = '0, req_cell_row = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [6:0] rsp_cell_cost;
   logic [11:0] rsp_out_col, rsp_out_row;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [23:0] csr_wdata = '0;

   proxemic_scoreboard sb = new();
   bit idle_on;
   int burst_left;
   bit hold_start;
   int hold_cnt;
   int stall_cycles;
   int unsigned rx_cycle;

   social_proxemic_cell_cost_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_person_x(req_person_x), .req_person_y(req_person_y),
      .req_person_vx(req_person_vx), .req_person_vy(req_person_vy),
      .req_cell_col(req_cell_col), .req_cell_row(req_cell_row),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_cell_cost(rsp_cell_cost),
      .rsp_out_col(rsp_out_col), .rsp_out_row(rsp_out_row),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: checks, random stall pattern, one long hold-off on request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_cell_cost, rsp_out_col, rsp_out_row);
         rx_cycle++;
         if (hold_start) begin
            hold_start = 1'b0;
            hold_cnt = LONG_HOLD;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 1'b0;
         end else begin
            case ((rx_cycle / 97) % 4)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (rx_cycle % 5) != 0;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send(request_type r);
      int gap;
      req_valid <= 1'b1;
      req_type <= r.kind;
      req_person_x <= r.x;
      req_person_y <= r.y;
      req_person_vx <= r.vx;
      req_person_vy <= r.vy;
      req_cell_col <= r.col;
      req_cell_row <= r.row;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      if (idle_on) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.cost_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [23:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, v);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic request_type make(logic [1:0] kind, longint x, longint y,
                                        longint vx, longint vy, int col, int row);
      request_type r;
      r.kind = kind;
      r.x = x[23:0];
      r.y = y[23:0];
      r.vx = vx[15:0];
      r.vy = vy[15:0];
      r.col = col[11:0];
      r.row = row[11:0];
      return r;
   endfunction

   function automatic request_type noise();
      request_type r;
      r.kind = 2'($urandom_range(0, 3));
      r.x = 24'($urandom);
      r.y = 24'($urandom);
      r.vx = 16'($urandom);
      r.vy = 16'($urandom);
      r.col = 12'($urandom);
      r.row = 12'($urandom);
      return r;
   endfunction

   function automatic longint clamp24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic logic [15:0] pick16(int lo, int hi);
      case ($urandom_range(0, 7))
         0: return 16'hFFFF;
         1: return 16'(lo);
         default: return 16'($urandom_range(lo, hi));
      endcase
   endfunction

   task automatic add_near(int col, int row);
      longint span, cx, cy, vx, vy;
      span = longint'(sb.cutoff) + longint'(sb.cell_sz) + 4;
      cx = sb.centre(sb.org_x, 12'(col)) + longint'($urandom_range(0, 2 * span)) - span;
      cy = sb.centre(sb.org_y, 12'(row)) + longint'($urandom_range(0, 2 * span)) - span;
      if ($urandom_range(0, 3) == 0) begin
         vx = longint'($urandom_range(0, 2)) - 1;
         vy = longint'($urandom_range(0, 2)) - 1;
      end else begin
         vx = longint'($urandom_range(0, 65535)) - 32768;
         vy = longint'($urandom_range(0, 65535)) - 32768;
      end
      send(make(REQ_ADD, clamp24(cx), clamp24(cy), vx, vy, 0, 0));
   endtask

   initial begin
      int base_col, base_row, npersons, nq, sent;
      idle_on = 1'b0;
      burst_left = 0;
      hold_start = 1'b0;
      hold_cnt = 0;
      stall_cycles = 0;
      rx_cycle = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings, corner velocities, full table, unknown code
      send(make(REQ_QUERY, 0, 0, 0, 0, 0, 0));
      send(make(REQ_ADD, 25, 25, 0, 0, 0, 0));
      send(make(REQ_QUERY, 0, 0, 0, 0, 0, 0));
      send(make(REQ_QUERY, 0, 0, 0, 0, 10, 0));
      send(make(REQ_QUERY, 0, 0, 0, 0, 0, 5));
      send(make(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
      send(make(REQ_ADD, 500, 500, 1, 0, 0, 0));
      send(make(REQ_ADD, 1000, 1000, -32768, -32768, 0, 0));
      send(make(REQ_ADD, 100, 700, 32767, 32767, 0, 0));
      send(make(REQ_ADD, -8388608, 8388607, 0, -1, 0, 0));
      send(make(REQ_QUERY, 0, 0, 0, 0, 9, 9));
      send(make(REQ_QUERY, 0, 0, 0, 0, 20, 20));
      send(make(REQ_QUERY, 0, 0, 0, 0, 4095, 4095));
      send(make(REQ_UNUSED, -1, -1, -1, -1, 4095, 4095));
      for (int i = 0; i < 14; i++) send(make(REQ_ADD, 300 + 40 * i, 300, -i, i, 0, 0));
      send(make(REQ_QUERY, 0, 0, 0, 0, 6, 5));
      drain();

      write_reg(CSR_MAJOR, 24'd1);
      write_reg(CSR_MINOR, 24'd65535);
      write_reg(CSR_RADIUS, 24'd65535);
      write_reg(CSR_CUTOFF, 24'd0);
      write_reg(CSR_ORIGIN_X, 24'h800000);
      write_reg(CSR_ORIGIN_Y, 24'h7FFFFF);
      write_reg(CSR_CELL, 24'd1);

      sent = 0;
      for (int phase = 0; sent < 1400; phase++) begin
         drain();
         if (phase > 0) begin
            write_reg(CSR_MAJOR, 24'(pick16(1, 4000)));
            write_reg(CSR_MINOR, 24'(pick16(1, 3000)));
            write_reg(CSR_RADIUS, ($urandom_range(0, 9) == 0) ? 24'd0 :
                                  24'(pick16(1, 3000)));
            write_reg(CSR_CUTOFF, ($urandom_range(0, 9) == 0) ? 24'd0 :
                                  24'(pick16(100, 6000)));
            write_reg(CSR_ORIGIN_X, ($urandom_range(0, 5) == 0) ? 24'($urandom) :
                                    24'(longint'($urandom_range(0, 20000)) - 10000));
            write_reg(CSR_ORIGIN_Y, ($urandom_range(0, 5) == 0) ? 24'($urandom) :
                                    24'(longint'($urandom_range(0, 20000)) - 10000));
            write_reg(CSR_CELL, 24'(pick16(1, 200)));
         end
         idle_on = (phase % 3) != 2;
         if (phase == 4) begin
            idle_on = 1'b0;
            hold_start = 1'b1;
         end
         base_col = $urandom_range(0, 4000);
         base_row = $urandom_range(0, 4000);
         send(make(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
         npersons = $urandom_range(1, 18);
         for (int p = 0; p < npersons; p++)
            add_near(base_col + $urandom_range(0, 6), base_row + $urandom_range(0, 6));
         nq = $urandom_range(40, 90);
         for (int q = 0; q < nq; q++) begin
            if ($urandom_range(0, 19) == 0)
               send(noise());
            else
               send(make(REQ_QUERY, 0, 0, 0, 0, base_col + $urandom_range(0, 8) - 1,
                         base_row + $urandom_range(0, 8) - 1));
         end
         sent += npersons + nq + 1;
      end

      drain();
      repeat (100) @(posedge clock);
      if (sb.fails == 0 && sb.cost_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/sprox_pkg.sv
rtl/sprox_ram.sv
rtl/sprox_mul.sv
rtl/sprox_div.sv
rtl/sprox_core.sv
rtl/social_proxemic_cell_cost_unit.sv
rtl/sprox_checker.sv
dv/tb_social_proxemic_cell_cost_unit.sv
